// ===== hw/rtl/ffa_pkg.sv =====
package ffa_pkg;

   // heap geometry
   localparam int HEAP_BYTES = 4096;
   localparam int NGRAN      = HEAP_BYTES / 16;
   localparam int GW         = $clog2(NGRAN);
   localparam int LW         = GW + 1;
   localparam int ALU_W      = 14;

   localparam logic [LW-1:0] NULL_LINK = LW'(NGRAN);

   // commands
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // result status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_NOFIT   = 2'd1;
   localparam logic [1:0] STAT_BADFREE = 2'd2;

   // per-granule chunk info
   typedef struct packed {
      logic [LW-1:0] gran;
      logic          start;
      logic          in_use;
   } info_type;

   // sequencer states
   typedef enum logic [10:0] {
      S_CLEAR  = 11'b000_0000_0001,
      S_IDLE   = 11'b000_0000_0010,
      S_NEED   = 11'b000_0000_0100,
      S_CHECK  = 11'b000_0000_1000,
      S_RD     = 11'b000_0001_0000,
      S_EVAL   = 11'b000_0010_0000,
      S_UNLINK = 11'b000_0100_0000,
      S_SPLIT  = 11'b000_1000_0000,
      S_PUSH1  = 11'b001_0000_0000,
      S_PUSH2  = 11'b010_0000_0000,
      S_DONE   = 11'b100_0000_0000
   } state_type;

endpackage

// ===== hw/rtl/ffa_ram.sv =====
module ffa_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = ffa_pkg::NGRAN
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== hw/rtl/ffa_alu.sv =====
module ffa_alu (
   input  logic [ffa_pkg::ALU_W-1:0] a,
   input  logic [ffa_pkg::ALU_W-1:0] b,
   input  logic                      sub,
   output logic [ffa_pkg::ALU_W-1:0] sum,
   output logic                      ge
);

   logic [ffa_pkg::ALU_W:0] full;

   // shared adder; on subtract the carry out means a >= b
   assign full = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{ffa_pkg::ALU_W{1'b0}}, sub};
   assign sum  = full[ffa_pkg::ALU_W-1:0];
   assign ge   = full[ffa_pkg::ALU_W];

endmodule

// ===== hw/rtl/first_fit_free_list_allocator.sv =====
// channel | direction | fields
// req     | in        | req_command, req_request_bytes, req_payload_offset_in
// rsp     | out       | rsp_status, rsp_payload_offset_out, rsp_chunk_bytes, rsp_free_total
//
// after reset a clearing pass over every granule initializes the chunk tables; req_ready stays low
// allocate: size and check, walk the free chunks, unlink, split and push any remainder
// free: read, check, push; a misaligned offset fails at once, a bad start at the check
// each walk step costs one registered read of the chunk tables
// one transaction in flight; a finished result waits in the output register while the next
// transaction is taken, and the sequencer holds only if a second result is ready first
module first_fit_free_list_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [12:0] req_request_bytes,
   input  logic [11:0] req_payload_offset_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [11:0] rsp_payload_offset_out,
   output logic [12:0] rsp_chunk_bytes,
   output logic [12:0] rsp_free_total
);

   localparam int GW = ffa_pkg::GW;
   localparam int LW = ffa_pkg::LW;
   localparam int AW = ffa_pkg::ALU_W;

   ffa_pkg::state_type state_ff, state_in;
   logic [GW-1:0] clr_ff, clr_in;
   logic [LW-1:0] head_ff, head_in;
   logic [12:0]   free_ff, free_in;
   logic          cmd_ff, cmd_in;
   logic [12:0]   req_ff, req_in;
   logic [9:0]    need_ff, need_in;
   logic [LW-1:0] cur_ff, cur_in;
   logic [GW-1:0] step_ff, step_in;
   logic [LW-1:0] g_ff, g_in;
   logic [LW-1:0] rem_ff, rem_in;
   logic [LW-1:0] p_ff, p_in;
   logic [LW-1:0] n_ff, n_in;
   logic [GW-1:0] pn_ff, pn_in;
   logic [LW-1:0] pgran_ff, pgran_in;
   logic [1:0]    st_ff, st_in;
   logic [11:0]   pay_ff, pay_in;
   logic [12:0]   bytes_ff, bytes_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [11:0]   rsp_pay_ff, rsp_pay_in;
   logic [12:0]   rsp_bytes_ff, rsp_bytes_in;
   logic [12:0]   rsp_free_ff, rsp_free_in;

   // memory ports
   logic                info_we, fwd_we, bwd_we;
   logic [GW-1:0]       info_wa, fwd_wa, bwd_wa;
   ffa_pkg::info_type   info_wd, info_rd;
   logic [LW-1:0]       fwd_wd, bwd_wd, fwd_rd, bwd_rd;

   // shared adder ports
   logic [AW-1:0] alu_a, alu_b, alu_sum;
   logic          alu_sub, alu_ge;

   ffa_ram #(.WIDTH($bits(ffa_pkg::info_type)), .DEPTH(ffa_pkg::NGRAN)) u_info (
      .clock(clock), .we(info_we), .waddr(info_wa), .wdata(info_wd),
      .raddr(cur_ff[GW-1:0]), .rdata(info_rd)
   );

   ffa_ram #(.WIDTH(LW), .DEPTH(ffa_pkg::NGRAN)) u_fwd (
      .clock(clock), .we(fwd_we), .waddr(fwd_wa), .wdata(fwd_wd),
      .raddr(cur_ff[GW-1:0]), .rdata(fwd_rd)
   );

   ffa_ram #(.WIDTH(LW), .DEPTH(ffa_pkg::NGRAN)) u_bwd (
      .clock(clock), .we(bwd_we), .waddr(bwd_wa), .wdata(bwd_wd),
      .raddr(cur_ff[GW-1:0]), .rdata(bwd_rd)
   );

   ffa_alu u_alu (
      .a(alu_a), .b(alu_b), .sub(alu_sub), .sum(alu_sum), .ge(alu_ge)
   );

   // adder operand select per step
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      case (state_ff)
         ffa_pkg::S_NEED: begin
            alu_a = AW'(req_ff);
            alu_b = AW'(23);
         end
         ffa_pkg::S_CHECK: begin
            alu_a   = AW'(free_ff);
            alu_b   = {need_ff, 4'b0};
            alu_sub = 1'b1;
         end
         ffa_pkg::S_EVAL: begin
            alu_a   = AW'(info_rd.gran);
            alu_b   = AW'(need_ff);
            alu_sub = 1'b1;
         end
         ffa_pkg::S_UNLINK: begin
            alu_a   = AW'(free_ff);
            alu_b   = AW'({g_ff, 4'b0});
            alu_sub = 1'b1;
         end
         ffa_pkg::S_SPLIT: begin
            alu_a = AW'(cur_ff);
            alu_b = AW'(need_ff);
         end
         ffa_pkg::S_PUSH2: begin
            alu_a = AW'(free_ff);
            alu_b = AW'({pgran_ff, 4'b0});
         end
         default: begin
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      head_in       = head_ff;
      free_in       = free_ff;
      cmd_in        = cmd_ff;
      req_in        = req_ff;
      need_in       = need_ff;
      cur_in        = cur_ff;
      step_in       = step_ff;
      g_in          = g_ff;
      rem_in        = rem_ff;
      p_in          = p_ff;
      n_in          = n_ff;
      pn_in         = pn_ff;
      pgran_in      = pgran_ff;
      st_in         = st_ff;
      pay_in        = pay_ff;
      bytes_in      = bytes_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pay_in    = rsp_pay_ff;
      rsp_bytes_in  = rsp_bytes_ff;
      rsp_free_in   = rsp_free_ff;
      info_we       = 1'b0;
      info_wa       = '0;
      info_wd       = '0;
      fwd_we        = 1'b0;
      fwd_wa        = '0;
      fwd_wd        = '0;
      bwd_we        = 1'b0;
      bwd_wa        = '0;
      bwd_wd        = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ffa_pkg::S_CLEAR: begin
            info_we = 1'b1;
            info_wa = clr_ff;
            if (clr_ff == '0) begin
               info_wd.gran  = LW'(ffa_pkg::NGRAN);
               info_wd.start = 1'b1;
            end
            fwd_we = 1'b1;
            fwd_wa = clr_ff;
            fwd_wd = ffa_pkg::NULL_LINK;
            bwd_we = 1'b1;
            bwd_wa = clr_ff;
            bwd_wd = ffa_pkg::NULL_LINK;
            clr_in = clr_ff + GW'(1);
            if (clr_ff == GW'(ffa_pkg::NGRAN - 1)) begin
               state_in = ffa_pkg::S_IDLE;
            end
         end
         ffa_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_command;
               req_in   = req_request_bytes;
               st_in    = ffa_pkg::STAT_OK;
               pay_in   = '0;
               bytes_in = '0;
               if (req_command == ffa_pkg::CMD_ALLOC) begin
                  state_in = ffa_pkg::S_NEED;
               end else if (req_payload_offset_in[3:0] == 4'h4) begin
                  cur_in   = LW'(req_payload_offset_in[11:4]);
                  state_in = ffa_pkg::S_RD;
               end else begin
                  st_in    = ffa_pkg::STAT_BADFREE;
                  state_in = ffa_pkg::S_DONE;
               end
            end
         end
         ffa_pkg::S_NEED: begin
            need_in  = alu_sum[13:4];
            state_in = ffa_pkg::S_CHECK;
         end
         ffa_pkg::S_CHECK: begin
            cur_in  = head_ff;
            step_in = '0;
            if (alu_ge && !head_ff[GW]) begin
               state_in = ffa_pkg::S_RD;
            end else begin
               st_in    = ffa_pkg::STAT_NOFIT;
               state_in = ffa_pkg::S_DONE;
            end
         end
         ffa_pkg::S_RD: begin
            state_in = ffa_pkg::S_EVAL;
         end
         ffa_pkg::S_EVAL: begin
            if (cmd_ff == ffa_pkg::CMD_FREE) begin
               // free: must be an allocated chunk start
               if (info_rd.start && info_rd.in_use) begin
                  pn_in    = cur_ff[GW-1:0];
                  pgran_in = info_rd.gran;
                  bytes_in = {info_rd.gran, 4'b0};
                  state_in = ffa_pkg::S_PUSH1;
               end else begin
                  st_in    = ffa_pkg::STAT_BADFREE;
                  state_in = ffa_pkg::S_DONE;
               end
            end else if (alu_ge) begin
               // first fit found
               g_in     = info_rd.gran;
               rem_in   = alu_sum[LW-1:0];
               p_in     = bwd_rd;
               n_in     = fwd_rd;
               pay_in   = {cur_ff[GW-1:0], 4'h4};
               bytes_in = {need_ff[LW-1:0], 4'b0};
               state_in = ffa_pkg::S_UNLINK;
            end else if (fwd_rd[GW] || step_ff == GW'(ffa_pkg::NGRAN - 1)) begin
               st_in    = ffa_pkg::STAT_NOFIT;
               state_in = ffa_pkg::S_DONE;
            end else begin
               cur_in   = fwd_rd;
               step_in  = step_ff + GW'(1);
               state_in = ffa_pkg::S_RD;
            end
         end
         ffa_pkg::S_UNLINK: begin
            if (!p_ff[GW]) begin
               fwd_we = 1'b1;
               fwd_wa = p_ff[GW-1:0];
               fwd_wd = n_ff;
            end else begin
               head_in = n_ff;
            end
            if (!n_ff[GW]) begin
               bwd_we = 1'b1;
               bwd_wa = n_ff[GW-1:0];
               bwd_wd = p_ff;
            end
            info_we        = 1'b1;
            info_wa        = cur_ff[GW-1:0];
            info_wd.gran   = (rem_ff != '0) ? need_ff[LW-1:0] : g_ff;
            info_wd.start  = 1'b1;
            info_wd.in_use = 1'b1;
            free_in        = alu_sum[12:0];
            state_in       = (rem_ff != '0) ? ffa_pkg::S_SPLIT : ffa_pkg::S_DONE;
         end
         ffa_pkg::S_SPLIT: begin
            // remainder chunk only if it starts inside the heap
            if (alu_sum[AW-1:GW] == '0) begin
               pn_in    = alu_sum[GW-1:0];
               pgran_in = rem_ff;
               state_in = ffa_pkg::S_PUSH1;
            end else begin
               state_in = ffa_pkg::S_DONE;
            end
         end
         ffa_pkg::S_PUSH1: begin
            info_we        = 1'b1;
            info_wa        = pn_ff;
            info_wd.gran   = pgran_ff;
            info_wd.start  = 1'b1;
            info_wd.in_use = 1'b0;
            fwd_we         = 1'b1;
            fwd_wa         = pn_ff;
            fwd_wd         = head_ff;
            bwd_we         = 1'b1;
            bwd_wa         = pn_ff;
            bwd_wd         = ffa_pkg::NULL_LINK;
            state_in       = ffa_pkg::S_PUSH2;
         end
         ffa_pkg::S_PUSH2: begin
            if (!head_ff[GW]) begin
               bwd_we = 1'b1;
               bwd_wa = head_ff[GW-1:0];
               bwd_wd = LW'(pn_ff);
            end
            head_in  = LW'(pn_ff);
            free_in  = alu_sum[12:0];
            state_in = ffa_pkg::S_DONE;
         end
         ffa_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_pay_in    = pay_ff;
               rsp_bytes_in  = bytes_ff;
               rsp_free_in   = free_ff;
               state_in      = ffa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ffa_pkg::S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffa_pkg::S_CLEAR;
         clr_ff       <= '0;
         head_ff      <= '0;
         free_ff      <= 13'(ffa_pkg::HEAP_BYTES);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         head_ff      <= head_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      req_ff        <= req_in;
      need_ff       <= need_in;
      cur_ff        <= cur_in;
      step_ff       <= step_in;
      g_ff          <= g_in;
      rem_ff        <= rem_in;
      p_ff          <= p_in;
      n_ff          <= n_in;
      pn_ff         <= pn_in;
      pgran_ff      <= pgran_in;
      st_ff         <= st_in;
      pay_ff        <= pay_in;
      bytes_ff      <= bytes_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pay_ff    <= rsp_pay_in;
      rsp_bytes_ff  <= rsp_bytes_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign req_ready              = (state_ff == ffa_pkg::S_IDLE);
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_payload_offset_out = rsp_pay_ff;
   assign rsp_chunk_bytes        = rsp_bytes_ff;
   assign rsp_free_total         = rsp_free_ff;

endmodule

// ===== hw/rtl/ffa_checker.sv =====
module ffa_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [11:0] rsp_payload_offset_out,
   input logic [12:0] rsp_chunk_bytes,
   input logic [12:0] rsp_free_total
);

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_free_total))
      else $error("stalled result changed");

   // failures carry no offset and no size
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ffa_pkg::STAT_NOFIT || rsp_status == ffa_pkg::STAT_BADFREE)
      |-> rsp_payload_offset_out == '0 && rsp_chunk_bytes == '0)
      else $error("failed transaction has nonzero fields");

   // free total never exceeds the heap
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_free_total <= 13'(ffa_pkg::HEAP_BYTES))
      else $error("free total beyond heap");

   // allocated offsets sit 4 bytes into a granule
   a_align: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ffa_pkg::STAT_OK && rsp_payload_offset_out != '0
      |-> rsp_payload_offset_out[3:0] == 4'h4)
      else $error("misaligned payload offset");

endmodule

bind first_fit_free_list_allocator ffa_checker u_ffa_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_status(rsp_status),
   .rsp_payload_offset_out(rsp_payload_offset_out),
   .rsp_chunk_bytes(rsp_chunk_bytes),
   .rsp_free_total(rsp_free_total)
);
